// ===== hdl/kdar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_pkg
// Shared types, constants and helpers for the key debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package kdar_pkg;

  localparam int KEY_BITS_DEF = 4;

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int HOLD_BITS = 8;
  localparam int PRESS_BITS = 3;

  // Register reset values.
  localparam logic [HOLD_BITS-1:0] DEBOUNCE_RST = 8'd5;
  localparam logic [HOLD_BITS-1:0] RPT_TICKS_RST = 8'd63;
  localparam logic [HOLD_BITS-1:0] RELEASE_RST = 8'd15;
  localparam logic [PRESS_BITS-1:0] SLOW_LIMIT_RST = 3'd4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_RPT_TICKS  = 2'd1,
    CFG_RELEASE    = 2'd2,
    CFG_SLOW_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [HOLD_BITS-1:0]  debounce;
    logic [HOLD_BITS-1:0]  rpt_ticks;
    logic [HOLD_BITS-1:0]  release_step;
    logic [PRESS_BITS-1:0] slow_limit;
  } cfg_t;

  function automatic logic [HOLD_BITS-1:0] sat_inc_hold(input logic [HOLD_BITS-1:0] v);
    sat_inc_hold = (v == {HOLD_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [PRESS_BITS-1:0] sat_inc_press(input logic [PRESS_BITS-1:0] v);
    sat_inc_press = (v == {PRESS_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/kdar_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_core
// Debounce state registers and the per-word update that computes the result.
// ----------------------------------------------------------------------------
module kdar_core #(
  parameter int KEY_BITS = kdar_pkg::KEY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic [KEY_BITS-1:0]              raw,
  input  kdar_pkg::cfg_t                   cfg,
  output logic [KEY_BITS-1:0]              key_code,
  output logic                             key_event,
  output logic                             fast_repeat
);

  localparam logic [KEY_BITS-1:0] IDLE_CODE = {KEY_BITS{1'b1}};

  logic [KEY_BITS-1:0]             prev_r, prev_nxt;
  logic [KEY_BITS-1:0]             acc_r, acc_nxt;
  logic [kdar_pkg::HOLD_BITS-1:0]  hold_r, hold_nxt, hold_inc;
  logic [kdar_pkg::PRESS_BITS-1:0] press_r, press_nxt, press_acc;
  logic                            fast_r, fast_nxt;
  logic                            event_nxt;

  always_comb begin
    prev_nxt  = prev_r;
    acc_nxt   = acc_r;
    hold_nxt  = hold_r;
    press_nxt = press_r;
    fast_nxt  = fast_r;
    event_nxt = 1'b0;
    press_acc = press_r;
    hold_inc  = kdar_pkg::sat_inc_hold(hold_r);
    if (raw != prev_r) begin
      // Code change: back the hold counter off and restart the press count.
      prev_nxt  = raw;
      press_nxt = '0;
      fast_nxt  = 1'b0;
      if (hold_r > cfg.release_step) begin
        hold_nxt = hold_r - cfg.release_step;
      end else if (hold_r > cfg.debounce) begin
        hold_nxt = hold_r - cfg.debounce;
      end else begin
        hold_nxt = '0;
      end
    end else if (raw == IDLE_CODE) begin
      acc_nxt  = IDLE_CODE;
      hold_nxt = '0;
    end else if (hold_r < cfg.debounce) begin
      hold_nxt = hold_inc;
    end else begin
      acc_nxt = raw;
      if (hold_r == cfg.debounce) begin
        press_acc = kdar_pkg::sat_inc_press(press_r);
        event_nxt = 1'b1;
      end
      if (press_acc >= cfg.slow_limit) begin
        fast_nxt = 1'b1;
      end
      if (hold_inc == cfg.rpt_ticks) begin
        hold_nxt  = '0;
        press_nxt = kdar_pkg::sat_inc_press(press_acc);
      end else begin
        hold_nxt  = hold_inc;
        press_nxt = press_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      acc_r   <= '0;
      hold_r  <= '0;
      press_r <= '0;
      fast_r  <= 1'b0;
    end else if (fire) begin
      prev_r  <= prev_nxt;
      acc_r   <= acc_nxt;
      hold_r  <= hold_nxt;
      press_r <= press_nxt;
      fast_r  <= fast_nxt;
    end
  end

  assign key_code    = acc_nxt;
  assign key_event   = event_nxt;
  assign fast_repeat = fast_nxt;

endmodule

// ===== hdl/key_debounce_auto_repeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat
// Key debouncer with auto-repeat: one raw key sample in, one report out.
// ----------------------------------------------------------------------------
// Each accepted input word is one raw, active-low key sample (all ones means
// no key). Every word produces exactly one output word carrying the debounced
// key code, an event pulse for a new or repeated press, and the fast-repeat
// flag. The block takes one word per clock cycle while out_stall is low; a
// word is registered on entry, runs through the combinational state update,
// and its result lands in the output register, so out_valid rises when the
// word moves from the input register into the output register.
// The state update is one short compare-and-add pass, which is what holds the
// rate at one word per cycle without stalls. When out_stall is held, the input
// register keeps its word and in_stall rises only once both registers are occupied.
// Configuration registers (debounce, repeat period, release step and
// slow-repeat limit) are written through the cfg port, which is always ready;
// they should only be changed while no word is in flight.
// ----------------------------------------------------------------------------
module key_debounce_auto_repeat #(
  parameter int KEY_BITS = kdar_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [KEY_BITS-1:0]                 in_raw_keys,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [KEY_BITS-1:0]                 out_key_code,
  output logic                                out_key_event,
  output logic                                out_fast_repeat,
  // Configuration write port.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kdar_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [kdar_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  kdar_pkg::cfg_t cfg_r;

  logic                in_valid_r;
  logic [KEY_BITS-1:0] raw_r;
  logic                out_valid_r;
  logic [KEY_BITS-1:0] key_code_r;
  logic                key_event_r;
  logic                fast_r;

  logic                advance;
  logic                fire;
  logic                in_take;
  logic [KEY_BITS-1:0] core_key_code;
  logic                core_key_event;
  logic                core_fast;

  // The output register frees up when it is empty or its word is taken.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce     <= kdar_pkg::DEBOUNCE_RST;
      cfg_r.rpt_ticks    <= kdar_pkg::RPT_TICKS_RST;
      cfg_r.release_step <= kdar_pkg::RELEASE_RST;
      cfg_r.slow_limit   <= kdar_pkg::SLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (kdar_pkg::cfg_idx_t'(cfg_index))
        kdar_pkg::CFG_DEBOUNCE:   cfg_r.debounce     <= cfg_data;
        kdar_pkg::CFG_RPT_TICKS:  cfg_r.rpt_ticks    <= cfg_data;
        kdar_pkg::CFG_RELEASE:    cfg_r.release_step <= cfg_data;
        kdar_pkg::CFG_SLOW_LIMIT: cfg_r.slow_limit   <= cfg_data[kdar_pkg::PRESS_BITS-1:0];
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_r <= in_raw_keys;
    end
  end

  // State update; the state advances only when the word moves to the output.
  kdar_core #(
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .raw         (raw_r),
    .cfg         (cfg_r),
    .key_code    (core_key_code),
    .key_event   (core_key_event),
    .fast_repeat (core_fast)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_code_r  <= core_key_code;
      key_event_r <= core_key_event;
      fast_r      <= core_fast;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_code    = key_code_r;
  assign out_key_event   = key_event_r;
  assign out_fast_repeat = fast_r;

endmodule
